// File: sv/grc_pkg.sv
// Shared types and constants of the grid ray wall caster.
package grc_pkg;

    localparam int START_W  = 14;
    localparam int TOWARD_W = 16;
    localparam int D_W      = 17;
    localparam int DEN_W    = 16;
    localparam int HIT_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int SQ_W     = 62;
    localparam int DIST_W   = 63;

    localparam logic [31:0] OFFSET_SAT = 32'h7FFF_FFFF;
    localparam logic [CFG_W-1:0] MAP_DIM_RESET = 7'd64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_WALL    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NODIR   = 2'd2;

    localparam logic AX_X = 1'b0;
    localparam logic AX_Y = 1'b1;

    typedef struct packed {
        logic clear;
        logic wr;
        logic load;
        logic amul;
        logic div_go;
        logic div_sel;
        logic take0;
        logic take1;
        logic sq;
        logic sum;
        logic pick;
        logic rd;
        logic emit;
        logic emit_nodir;
        logic axis;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic dx_zero;
        logic dy_zero;
        logic div_done;
        logic stop;
        logic adv_y;
    } st_t;

endpackage

// File: sv/grc_div.sv
// Bit-serial floor divider: signed dividend by positive divisor.
module grc_div
    import grc_pkg::*;
#(
    parameter int NW  = 26,
    parameter int DVW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic signed [NW-1:0]  num,
    input  logic        [DVW-1:0] den,
    output logic                  done,
    output logic signed [NW-1:0]  quo,
    output logic        [DVW-1:0] rem
);

    localparam int CNW = $clog2(NW + 1);

    logic           run_reg;
    logic           fix_reg;
    logic           done_reg;
    logic [CNW-1:0] cnt_reg;
    logic           neg_reg;
    logic [NW-1:0]  mag_reg;
    logic [DVW-1:0] rem_reg;
    logic [DVW-1:0] den_reg;
    logic signed [NW-1:0] quo_reg;
    logic [DVW-1:0] remo_reg;

    logic [DVW:0]   trial;
    logic           ge;
    logic [DVW:0]   diff;
    logic [DVW-1:0] rem_next;

    assign trial    = {rem_reg, mag_reg[NW-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    assign rem_next = ge ? diff[DVW-1:0] : trial[DVW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fix_reg;
            fix_reg  <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNW'(1);
                if (cnt_reg == CNW'(1))
                begin
                    run_reg <= 1'b0;
                    fix_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            neg_reg <= num[NW-1];
            mag_reg <= num[NW-1] ? NW'(-num) : NW'(num);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            mag_reg <= {mag_reg[NW-2:0], ge};
            rem_reg <= rem_next;
        end
        if (fix_reg)
        begin
            if (neg_reg && rem_reg != '0)
            begin
                quo_reg  <= $signed(~mag_reg);
                remo_reg <= den_reg - rem_reg;
            end
            else if (neg_reg)
            begin
                quo_reg  <= $signed(-mag_reg);
                remo_reg <= rem_reg;
            end
            else
            begin
                quo_reg  <= $signed(mag_reg);
                remo_reg <= rem_reg;
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = remo_reg;

endmodule

// File: sv/grc_dp.sv
// Datapath: wall map, crossing stepper, distance compare and result registers.
module grc_dp
    import grc_pkg::*;
#(
    parameter int MAP_SIDE  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    output st_t                         st,
    input  logic [5:0]                  cell_x,
    input  logic [5:0]                  cell_y,
    input  logic                        cell_wall,
    input  logic [START_W-1:0]          start_x,
    input  logic [START_W-1:0]          start_y,
    input  logic signed [TOWARD_W-1:0]  toward_x,
    input  logic signed [TOWARD_W-1:0]  toward_y,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    output logic signed [HIT_W-1:0]     hit_x,
    output logic signed [HIT_W-1:0]     hit_y,
    output logic                        hit_on_y_line,
    output logic [STATUS_W-1:0]         status
);

    localparam int AW    = $clog2(MAP_SIDE + 68) + FRAC_BITS;
    localparam int NW    = FRAC_BITS + D_W + 1;
    localparam int CW0   = AW + D_W + 1;
    localparam int CW    = (CW0 > 33) ? CW0 : 33;
    localparam int IW    = $clog2(MAP_SIDE);
    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int MW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAP_SIDE + 128);

    localparam logic signed [CW-1:0] HMAX = CW'(32767);
    localparam logic signed [CW-1:0] HMIN = ~HMAX;
    localparam logic [CW-1:0] QSAT = CW'(OFFSET_SAT);

    logic                 mem [DEPTH];
    logic [MW-1:0]        clr_addr_reg;
    logic [CFG_W-1:0]     map_width_reg;
    logic [CFG_W-1:0]     map_height_reg;

    logic [START_W-1:0]   sx_reg, sy_reg;
    logic signed [D_W-1:0] dx_reg, dy_reg;
    logic                 negx_reg, negy_reg;
    logic [AW-1:0]        ax_reg, ay_reg;
    logic signed [CW-1:0] qx_reg, qy_reg;
    logic [DEN_W-1:0]     rx_reg, ry_reg;
    logic signed [NW-1:0] qsx_reg, qsy_reg;
    logic [DEN_W-1:0]     rsx_reg, rsy_reg;
    logic signed [NW-1:0] prod_reg;
    logic [SQ_W-1:0]      p0_reg, p1_reg;
    logic [DIST_W-1:0]    distx_reg, disty_reg;
    logic signed [CW-1:0] hx_reg, hy_reg;
    logic                 ony_reg;
    logic                 advy_reg;
    logic                 rd_bit_reg;
    logic                 out_reg;
    logic signed [HIT_W-1:0] hit_x_reg, hit_y_reg;
    logic                 ony_out_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic signed [D_W-1:0] dx_in, dy_in;
    logic signed [CW-1:0] sxi, syi, sxc, syc;
    logic [AW-1:0]        unit_a;
    logic [AW-1:0]        ax0, ay0;
    logic                 take_x;
    logic                 sel_y;
    logic [AW-1:0]        a_sel;
    logic signed [CW-1:0] q_sel;
    logic [DEN_W-1:0]     r_sel;
    logic signed [NW-1:0] qs_sel;
    logic [DEN_W-1:0]     rs_sel;
    logic                 neg_sel;
    logic signed [D_W-1:0] d_axis, d_other;
    logic [D_W-1:0]       abs_d;
    logic [DEN_W-1:0]     den_sel;
    logic signed [AW:0]   a_s;
    logic signed [AW+D_W:0] prod_full;
    logic signed [NW-1:0] num_unit;
    logic signed [NW-1:0] div_num;
    logic                 div_done;
    logic signed [NW-1:0] div_quo;
    logic [DEN_W-1:0]     div_rem;
    logic [2*AW-1:0]      a_sq;
    logic [CW-1:0]        q_abs;
    logic [CW-1:0]        q_sat;
    logic [30:0]          q31;
    logic [SQ_W-1:0]      q_sq;
    logic [DEN_W:0]       r_sum;
    logic                 wrap;
    logic [DEN_W:0]       r_wr;
    logic [DEN_W-1:0]     r_new;
    logic signed [CW-1:0] q_new;
    logic [AW-1:0]        a_new;
    logic signed [CW-1:0] a_off;
    logic signed [CW-1:0] hx_new, hy_new;
    logic signed [CW-1:0] cx, cy;
    logic [SW-1:0]        mw, mh;
    logic                 outside;
    logic [MW-1:0]        rd_addr;
    logic [MW-1:0]        wr_addr;
    logic                 cell_ok;
    logic                 mem_we;
    logic [MW-1:0]        mem_wa;
    logic                 mem_wd;
    logic signed [HIT_W-1:0] hx_sat, hy_sat;

    assign dx_in  = $signed({toward_x[TOWARD_W-1], toward_x}) - $signed({3'b000, start_x});
    assign dy_in  = $signed({toward_y[TOWARD_W-1], toward_y}) - $signed({3'b000, start_y});
    assign sxi    = $signed(CW'(start_x));
    assign syi    = $signed(CW'(start_y));
    assign sxc    = $signed(CW'(sx_reg));
    assign syc    = $signed(CW'(sy_reg));
    assign unit_a = AW'(1) << FRAC_BITS;
    assign ax0    = dx_in[D_W-1] ? AW'(sxi[FRAC_BITS-1:0]) + AW'(1)
                                 : unit_a - AW'(sxi[FRAC_BITS-1:0]);
    assign ay0    = dy_in[D_W-1] ? AW'(syi[FRAC_BITS-1:0]) + AW'(1)
                                 : unit_a - AW'(syi[FRAC_BITS-1:0]);

    assign take_x = (dx_reg != '0) && ((dy_reg == '0) || (distx_reg < disty_reg));
    assign sel_y  = cmd.pick ? !take_x : cmd.axis;

    assign a_sel   = sel_y ? ay_reg  : ax_reg;
    assign q_sel   = sel_y ? qy_reg  : qx_reg;
    assign r_sel   = sel_y ? ry_reg  : rx_reg;
    assign qs_sel  = sel_y ? qsy_reg : qsx_reg;
    assign rs_sel  = sel_y ? rsy_reg : rsx_reg;
    assign neg_sel = sel_y ? negy_reg : negx_reg;
    assign d_axis  = sel_y ? dy_reg  : dx_reg;
    assign d_other = sel_y ? dx_reg  : dy_reg;
    assign abs_d   = d_axis[D_W-1] ? D_W'(-d_axis) : D_W'(d_axis);
    assign den_sel = abs_d[DEN_W-1:0];

    assign a_s       = $signed({1'b0, a_sel});
    assign prod_full = (AW+D_W+1)'(a_s) * (AW+D_W+1)'(d_other);
    assign num_unit  = NW'(d_other) <<< FRAC_BITS;
    assign div_num   = cmd.div_sel ? num_unit : prod_reg;

    grc_div #(
        .NW  (NW),
        .DVW (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.div_go),
        .num   (div_num),
        .den   (den_sel),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign a_sq  = (2*AW)'(a_sel) * (2*AW)'(a_sel);
    assign q_abs = q_sel[CW-1] ? CW'(-q_sel) : CW'(q_sel);
    assign q_sat = (q_abs > QSAT) ? QSAT : q_abs;
    assign q31   = q_sat[30:0];
    assign q_sq  = SQ_W'(q31) * SQ_W'(q31);

    assign r_sum = {1'b0, r_sel} + {1'b0, rs_sel};
    assign wrap  = r_sum >= {1'b0, den_sel};
    assign r_wr  = r_sum - {1'b0, den_sel};
    assign r_new = wrap ? r_wr[DEN_W-1:0] : r_sum[DEN_W-1:0];
    assign q_new = q_sel + CW'(qs_sel) + $signed(CW'(wrap));
    assign a_new = a_sel + unit_a;
    assign a_off = neg_sel ? -$signed(CW'(a_sel)) : $signed(CW'(a_sel));
    assign hx_new = sel_y ? sxc + q_sel : sxc + a_off;
    assign hy_new = sel_y ? syc + a_off : syc + q_sel;

    assign cx = hx_reg >>> FRAC_BITS;
    assign cy = hy_reg >>> FRAC_BITS;
    assign mw = (map_width_reg > MAP_SIDE) ? SW'(MAP_SIDE) : SW'(map_width_reg);
    assign mh = (map_height_reg > MAP_SIDE) ? SW'(MAP_SIDE) : SW'(map_height_reg);
    assign outside = hx_reg[CW-1] || hy_reg[CW-1] ||
                     (cx >= $signed(CW'(mw))) || (cy >= $signed(CW'(mh)));
    assign rd_addr = MW'(cy[IW-1:0] * MAP_SIDE) + MW'(cx[IW-1:0]);
    assign wr_addr = MW'(MW'(cell_y) * MAP_SIDE + MW'(cell_x));
    assign cell_ok = (cell_x < MAP_SIDE) && (cell_y < MAP_SIDE);

    assign mem_we = cmd.clear || (cmd.wr && cell_ok);
    assign mem_wa = cmd.clear ? clr_addr_reg : wr_addr;
    assign mem_wd = cmd.clear ? 1'b0 : cell_wall;

    assign hx_sat = (hx_reg > HMAX) ? HIT_W'(HMAX) :
                    (hx_reg < HMIN) ? HIT_W'(HMIN) : hx_reg[HIT_W-1:0];
    assign hy_sat = (hy_reg > HMAX) ? HIT_W'(HMAX) :
                    (hy_reg < HMIN) ? HIT_W'(HMIN) : hy_reg[HIT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd)
        begin
            rd_bit_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            map_width_reg  <= MAP_DIM_RESET;
            map_height_reg <= MAP_DIM_RESET;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + MW'(1);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                    CFG_MAP_HEIGHT: map_height_reg <= cfg_data;
                    default:        map_width_reg  <= map_width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg   <= start_x;
            sy_reg   <= start_y;
            dx_reg   <= dx_in;
            dy_reg   <= dy_in;
            negx_reg <= dx_in[D_W-1];
            negy_reg <= dy_in[D_W-1];
            ax_reg   <= ax0;
            ay_reg   <= ay0;
        end
        if (cmd.amul)
        begin
            prod_reg <= $signed(prod_full[NW-1:0]);
        end
        if (cmd.take0 && div_done)
        begin
            if (sel_y)
            begin
                qy_reg <= CW'(div_quo);
                ry_reg <= div_rem;
            end
            else
            begin
                qx_reg <= CW'(div_quo);
                rx_reg <= div_rem;
            end
        end
        if (cmd.take1 && div_done)
        begin
            if (sel_y)
            begin
                qsy_reg <= div_quo;
                rsy_reg <= div_rem;
            end
            else
            begin
                qsx_reg <= div_quo;
                rsx_reg <= div_rem;
            end
        end
        if (cmd.sq)
        begin
            p0_reg <= SQ_W'(a_sq);
            p1_reg <= q_sq;
        end
        if (cmd.sum)
        begin
            if (sel_y)
            begin
                disty_reg <= DIST_W'(p0_reg) + DIST_W'(p1_reg);
            end
            else
            begin
                distx_reg <= DIST_W'(p0_reg) + DIST_W'(p1_reg);
            end
        end
        if (cmd.pick)
        begin
            hx_reg   <= hx_new;
            hy_reg   <= hy_new;
            ony_reg  <= sel_y;
            advy_reg <= sel_y;
            if (sel_y)
            begin
                ay_reg <= a_new;
                qy_reg <= q_new;
                ry_reg <= r_new;
            end
            else
            begin
                ax_reg <= a_new;
                qx_reg <= q_new;
                rx_reg <= r_new;
            end
        end
        if (cmd.rd)
        begin
            out_reg <= outside;
        end
        if (cmd.emit)
        begin
            hit_x_reg   <= hx_sat;
            hit_y_reg   <= hy_sat;
            ony_out_reg <= ony_reg;
            status_reg  <= out_reg ? ST_OUTSIDE : ST_WALL;
        end
        else if (cmd.emit_nodir)
        begin
            hit_x_reg   <= '0;
            hit_y_reg   <= '0;
            ony_out_reg <= 1'b0;
            status_reg  <= ST_NODIR;
        end
    end

    assign st.clr_last = (clr_addr_reg == MW'(DEPTH - 1));
    assign st.dx_zero  = (dx_reg == '0);
    assign st.dy_zero  = (dy_reg == '0);
    assign st.div_done = div_done;
    assign st.stop     = out_reg || rd_bit_reg;
    assign st.adv_y    = advy_reg;

    assign hit_x         = hit_x_reg;
    assign hit_y         = hit_y_reg;
    assign hit_on_y_line = ony_out_reg;
    assign status        = status_reg;

endmodule

// File: sv/grc_ctrl.sv
// Controller: map clear, ray setup sequence and crossing walk.
module grc_ctrl
    import grc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic op,
    input  st_t  st,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_AMUL,
        S_D0GO,
        S_D0WAIT,
        S_D1GO,
        S_D1WAIT,
        S_SQ,
        S_SUM,
        S_PICK,
        S_RD,
        S_CHK
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && op == OP_CAST)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (st.dx_zero && st.dy_zero)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    axis_next  = st.dx_zero ? AX_Y : AX_X;
                    state_next = S_AMUL;
                end
            end
            S_AMUL:   state_next = S_D0GO;
            S_D0GO:   state_next = S_D0WAIT;
            S_D0WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_D1GO;
                end
            end
            S_D1GO:   state_next = S_D1WAIT;
            S_D1WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:     state_next = S_SUM;
            S_SUM:
            begin
                if (axis_reg == AX_X && !st.dy_zero)
                begin
                    axis_next  = AX_Y;
                    state_next = S_AMUL;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:   state_next = S_RD;
            S_RD:     state_next = S_CHK;
            S_CHK:
            begin
                if (st.stop)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            axis_reg  <= AX_X;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.clear      = (state_reg == S_CLEAR);
        cmd.wr         = (state_reg == S_IDLE) && start && (op == OP_WRITE);
        cmd.load       = (state_reg == S_IDLE) && start && (op == OP_CAST);
        cmd.amul       = (state_reg == S_AMUL);
        cmd.div_go     = (state_reg == S_D0GO) || (state_reg == S_D1GO);
        cmd.div_sel    = (state_reg == S_D1GO);
        cmd.take0      = (state_reg == S_D0WAIT);
        cmd.take1      = (state_reg == S_D1WAIT);
        cmd.sq         = (state_reg == S_SQ) || (state_reg == S_RD);
        cmd.sum        = (state_reg == S_SUM) || (state_reg == S_CHK);
        cmd.pick       = (state_reg == S_PICK);
        cmd.rd         = (state_reg == S_RD);
        cmd.emit       = (state_reg == S_CHK) && st.stop;
        cmd.emit_nodir = (state_reg == S_SETUP) && st.dx_zero && st.dy_zero;
        cmd.axis       = ((state_reg == S_RD) || (state_reg == S_CHK)) ? st.adv_y : axis_reg;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// File: sv/grid_ray_wall_caster_top.sv
// Top level of the grid ray wall caster.
// After reset the block clears its MAP_SIDE x MAP_SIDE wall map, one cell per cycle,
// with busy high. A cell write gives no result. A ray with no direction is answered
// from the setup step. Any other ray runs, for each axis on which it moves, two serial
// divisions at one quotient bit per cycle, after the setup step; then each grid-line
// crossing walked takes a pick, a map read and a compare. One ray is worked at a time.
// done is high for one cycle with the result; the result cannot be held off, and it
// appears in the cycle in which busy drops.
module grid_ray_wall_caster_top
    import grc_pkg::*;
#(
    parameter int MAP_SIDE  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        op,
    input  logic [5:0]                  cell_x,
    input  logic [5:0]                  cell_y,
    input  logic                        cell_wall,
    input  logic [START_W-1:0]          start_x,
    input  logic [START_W-1:0]          start_y,
    input  logic signed [TOWARD_W-1:0]  toward_x,
    input  logic signed [TOWARD_W-1:0]  toward_y,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    output logic                        done,
    output logic signed [HIT_W-1:0]     hit_x,
    output logic signed [HIT_W-1:0]     hit_y,
    output logic                        hit_on_y_line,
    output logic [STATUS_W-1:0]         status
);

    cmd_t cmd;
    st_t  st;

    assign cfg_ready = 1'b1;

    grc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    grc_dp #(
        .MAP_SIDE  (MAP_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .cell_wall     (cell_wall),
        .start_x       (start_x),
        .start_y       (start_y),
        .toward_x      (toward_x),
        .toward_y      (toward_y),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .hit_x         (hit_x),
        .hit_y         (hit_y),
        .hit_on_y_line (hit_on_y_line),
        .status        (status)
    );

endmodule

// File: sv/grc_checker.sv
// Port-level checker for the grid ray wall caster, bound to the top level.
module grc_checker
    import grc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    op,
    input logic                    done,
    input logic signed [HIT_W-1:0] hit_x,
    input logic signed [HIT_W-1:0] hit_y,
    input logic                    hit_on_y_line,
    input logic [STATUS_W-1:0]     status
);

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_WRITE) |=> (!busy && !done))
        else $error("cell write produced a beat or stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_WALL || status == ST_OUTSIDE || status == ST_NODIR))
        else $error("bad status code");

    a_nodir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NODIR) |-> (hit_x == '0 && hit_y == '0 && !hit_on_y_line))
        else $error("no-direction result not zero");

endmodule

bind grid_ray_wall_caster_top grc_checker u_grc_checker (.*);
